[design/rmb_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and defaults of the region mark bitmap
package rmb_pkg;

	localparam int ADDR_W             = 48;
	localparam int FUNC_W             = 3;
	localparam int COUNT_W            = 17;
	localparam int QUEUE_DEPTH        = 2;
	localparam int DEF_REGION_SLOTS   = 16;
	localparam int DEF_REGION_OFFSET  = 15;
	localparam int DEF_GRAIN_LOG      = 3;
	localparam int DEF_BITS_PER_REGION = 4096;
	localparam int DEF_ADDR_BITS      = 48;

	localparam logic [FUNC_W-1:0] FUNC_MARK       = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TEST       = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ITER_FIRST = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_ITER_NEXT  = 3'd4;

	typedef enum logic [2:0] {
		OP_MARK,
		OP_TEST,
		OP_CLEAR,
		OP_ITER_FIRST,
		OP_ITER_NEXT,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic              in_range;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WIPE,
		ST_READ,
		ST_UPDATE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               newly_marked;
		logic               is_marked;
		logic               table_full;
		logic [COUNT_W-1:0] marked_total;
		logic [ADDR_W-1:0]  next_addr;
		logic               iter_done;
	} res_t;

endpackage

[design/rmb_front.sv]
`timescale 1ns / 1ps
// front end: takes items, decodes the function and checks the word index
module rmb_front #(
	parameter int ADDR_BITS          = 48,
	parameter int REGION_OFFSET_BITS = 15,
	parameter int GRAIN_LOG          = 3,
	parameter int BITS_PER_REGION    = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rmb_pkg::FUNC_W-1:0] func,
	input  logic [rmb_pkg::ADDR_W-1:0] addr,
	output logic                       push,
	input  logic                       q_full,
	output rmb_pkg::cmd_t              cmd
);
	import rmb_pkg::*;

	localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
		ADDR_W'((65'd1 << ADDR_BITS) - 65'd1);
	localparam int IW = REGION_OFFSET_BITS - GRAIN_LOG;

	logic              valid_s1;
	cmd_t              cmd_s1;
	cmd_t              cmd_n;
	logic [ADDR_W-1:0] addr_m;
	logic [IW-1:0]     idx;
	logic              load;

	assign addr_m = addr & AMASK;
	assign idx    = addr_m[REGION_OFFSET_BITS-1:GRAIN_LOG];

	always_comb begin
		cmd_n.addr     = addr_m;
		cmd_n.in_range = 33'(idx) < 33'(BITS_PER_REGION);
		unique case (func)
			FUNC_MARK:       cmd_n.op = OP_MARK;
			FUNC_TEST:       cmd_n.op = OP_TEST;
			FUNC_CLEAR:      cmd_n.op = OP_CLEAR;
			FUNC_ITER_FIRST: cmd_n.op = OP_ITER_FIRST;
			FUNC_ITER_NEXT:  cmd_n.op = OP_ITER_NEXT;
			default:         cmd_n.op = OP_NONE;
		endcase
	end

	assign push     = valid_s1 & ~q_full;
	assign in_stall = valid_s1 & q_full;
	assign load     = in_valid & ~in_stall;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1 <= cmd_n;
		end
	end

endmodule

[design/rmb_queue.sv]
`timescale 1ns / 1ps
// short command queue between front and back end
module rmb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rmb_pkg::cmd_t push_cmd,
	input  logic          pop,
	output rmb_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import rmb_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] level_q;

	assign full  = level_q == CW'(QUEUE_DEPTH);
	assign empty = level_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

[design/rmb_back.sv]
`timescale 1ns / 1ps
// back end: region table, bitmap memory, mark, test, clear and scan
module rmb_back #(
	parameter int REGION_SLOTS       = 16,
	parameter int REGION_OFFSET_BITS = 15,
	parameter int GRAIN_LOG          = 3,
	parameter int BITS_PER_REGION    = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rmb_pkg::cmd_t               head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rmb_pkg::res_t               res
);
	import rmb_pkg::*;

	localparam int WPR    = (BITS_PER_REGION + 63) / 64;
	localparam int DEPTH  = REGION_SLOTS * WPR;
	localparam int MAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW     = (WPR > 1) ? $clog2(WPR) : 1;
	localparam int SW     = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int CSW    = $clog2(REGION_SLOTS + 1);
	localparam int BW     = $clog2(BITS_PER_REGION);
	localparam int BASE_W = ADDR_W - REGION_OFFSET_BITS;

	state_t             st_q, st_n;
	cmd_t               cmd_q;
	logic [SW-1:0]      slot_q;
	logic [WW-1:0]      wipe_q;
	logic [BASE_W-1:0]  slot_base_q [REGION_SLOTS];
	logic [REGION_SLOTS-1:0] slot_valid_q;
	logic [COUNT_W-1:0] count_q;
	logic [CSW-1:0]     cur_slot_q;
	logic [BW-1:0]      cur_bit_q;
	logic [63:0]        mem [DEPTH];
	logic [63:0]        rd_q;
	logic               r_new_q, r_is_q, r_full_q, r_done_q;
	logic [ADDR_W-1:0]  r_addr_q;
	res_t               res_q;
	logic               out_valid_q;

	logic [BASE_W-1:0]  base;
	logic [BW-1:0]      bnum;
	logic [WW-1:0]      word;
	logic               hit_any, free_any;
	logic [SW-1:0]      hit_idx, free_idx;
	logic [SW-1:0]      cur_sidx;
	logic               cur_end;
	logic               bitv;
	logic [63:0]        masked;
	logic               found;
	logic [5:0]         pos;
	logic [BW-1:0]      cbf;
	logic [BW:0]        cbf_inc;
	logic [BW:0]        nxt_word_bit;
	logic [63:0]        addr_sum;
	logic               out_free;
	logic               mem_we, mem_re;
	logic [MAW-1:0]     mem_a;
	logic [63:0]        mem_wd;

	function automatic logic [MAW-1:0] maddr(input logic [SW-1:0] s, input logic [WW-1:0] w);
		maddr = MAW'(MAW'(s) * MAW'(WPR) + MAW'(w));
	endfunction

	assign base     = cmd_q.addr[ADDR_W-1:REGION_OFFSET_BITS];
	assign bnum     = BW'(cmd_q.addr[REGION_OFFSET_BITS-1:GRAIN_LOG]);
	assign word     = WW'(bnum >> 6);
	assign cur_sidx = cur_slot_q[SW-1:0];
	assign cur_end  = cur_slot_q >= CSW'(REGION_SLOTS);
	assign bitv     = rd_q[bnum[5:0]];
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int s = REGION_SLOTS - 1; s >= 0; s--) begin
			if (slot_valid_q[s] && slot_base_q[s] == base) begin
				hit_any = 1'b1;
				hit_idx = SW'(s);
			end
			if (!slot_valid_q[s]) begin
				free_any = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	always_comb begin
		masked = rd_q & ({64{1'b1}} << cur_bit_q[5:0]);
		found  = |masked;
		pos    = '0;
		for (int i = 63; i >= 0; i--) begin
			if (masked[i]) begin
				pos = 6'(i);
			end
		end
		cbf          = (cur_bit_q & ~BW'(63)) | BW'(pos);
		cbf_inc      = {1'b0, cbf} + 1'b1;
		nxt_word_bit = ({1'b0, cur_bit_q} | (BW+1)'(63)) + 1'b1;
		addr_sum     = (64'(slot_base_q[cur_sidx]) << REGION_OFFSET_BITS) +
			(64'(cbf) << GRAIN_LOG);
	end

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: if (!empty) st_n = ST_EXEC;
			ST_EXEC: begin
				unique case (cmd_q.op)
					OP_MARK: begin
						if (!cmd_q.in_range) st_n = ST_OUT;
						else if (hit_any) st_n = ST_UPDATE;
						else if (free_any) st_n = ST_WIPE;
						else st_n = ST_OUT;
					end
					OP_TEST: st_n = (cmd_q.in_range && hit_any) ? ST_UPDATE : ST_OUT;
					OP_ITER_FIRST, OP_ITER_NEXT: st_n = ST_SCAN_RD;
					default: st_n = ST_OUT;
				endcase
			end
			ST_WIPE: if (wipe_q == WW'(WPR - 1)) st_n = ST_READ;
			ST_READ: st_n = ST_UPDATE;
			ST_UPDATE: st_n = ST_OUT;
			ST_SCAN_RD: begin
				if (cur_end) st_n = ST_OUT;
				else if (slot_valid_q[cur_sidx]) st_n = ST_SCAN_EV;
			end
			ST_SCAN_EV: st_n = found ? ST_OUT : ST_SCAN_RD;
			ST_OUT: if (out_free) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop    = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_a  = maddr(slot_q, word);
		mem_wd = '0;
		unique case (st_q)
			ST_IDLE: pop = ~empty;
			ST_EXEC: begin
				mem_a  = maddr(hit_idx, word);
				mem_re = (cmd_q.op == OP_MARK || cmd_q.op == OP_TEST) &&
					cmd_q.in_range && hit_any;
			end
			ST_WIPE: begin
				mem_a  = maddr(slot_q, wipe_q);
				mem_we = 1'b1;
			end
			ST_READ: mem_re = 1'b1;
			ST_UPDATE: begin
				mem_we = (cmd_q.op == OP_MARK) && !bitv;
				mem_wd = rd_q | (64'd1 << bnum[5:0]);
			end
			ST_SCAN_RD: begin
				mem_a  = maddr(cur_sidx, WW'(cur_bit_q >> 6));
				mem_re = ~cur_end & slot_valid_q[cur_sidx];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_a] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			slot_valid_q <= '0;
			count_q      <= '0;
			cur_slot_q   <= '0;
			cur_bit_q    <= '0;
			wipe_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_EXEC: begin
					wipe_q <= '0;
					if (cmd_q.op == OP_CLEAR) begin
						slot_valid_q <= '0;
						count_q      <= '0;
						cur_slot_q   <= '0;
						cur_bit_q    <= '0;
					end else if (cmd_q.op == OP_ITER_FIRST) begin
						cur_slot_q <= '0;
						cur_bit_q  <= '0;
					end else if (cmd_q.op == OP_MARK && cmd_q.in_range && !hit_any &&
						free_any) begin
						slot_valid_q[free_idx] <= 1'b1;
					end
				end
				ST_WIPE: wipe_q <= wipe_q + 1'b1;
				ST_UPDATE: begin
					if (cmd_q.op == OP_MARK && !bitv && count_q != {COUNT_W{1'b1}}) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_SCAN_RD: begin
					if (!cur_end && !slot_valid_q[cur_sidx]) begin
						cur_slot_q <= cur_slot_q + 1'b1;
						cur_bit_q  <= '0;
					end
				end
				ST_SCAN_EV: begin
					if (found) begin
						if (cbf_inc >= (BW+1)'(BITS_PER_REGION)) begin
							cur_slot_q <= cur_slot_q + 1'b1;
							cur_bit_q  <= '0;
						end else begin
							cur_bit_q <= cbf_inc[BW-1:0];
						end
					end else if (nxt_word_bit >= (BW+1)'(BITS_PER_REGION)) begin
						cur_slot_q <= cur_slot_q + 1'b1;
						cur_bit_q  <= '0;
					end else begin
						cur_bit_q <= nxt_word_bit[BW-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (!empty) cmd_q <= head;
			ST_EXEC: begin
				r_new_q  <= 1'b0;
				r_is_q   <= 1'b0;
				r_full_q <= cmd_q.op == OP_MARK && cmd_q.in_range && !hit_any && !free_any;
				r_done_q <= 1'b0;
				r_addr_q <= '0;
				slot_q   <= hit_any ? hit_idx : free_idx;
				if (cmd_q.op == OP_MARK && cmd_q.in_range && !hit_any && free_any) begin
					slot_base_q[free_idx] <= base;
				end
			end
			ST_UPDATE: begin
				if (cmd_q.op == OP_MARK) begin
					r_new_q <= ~bitv;
					r_is_q  <= 1'b1;
				end else begin
					r_is_q <= bitv;
				end
			end
			ST_SCAN_RD: if (cur_end) r_done_q <= 1'b1;
			ST_SCAN_EV: if (found) r_addr_q <= addr_sum[ADDR_W-1:0];
			ST_OUT: begin
				if (out_free) begin
					res_q.newly_marked <= r_new_q;
					res_q.is_marked    <= r_is_q;
					res_q.table_full   <= r_full_q;
					res_q.marked_total <= count_q;
					res_q.next_addr    <= r_addr_q;
					res_q.iter_done    <= r_done_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

[design/region_mark_bitmap_core.sv]
`timescale 1ns / 1ps
// top level of the region mark bitmap
//
// one input channel (in_valid, in_stall, func, addr) and one result channel
// (out_valid, out_stall and the six result fields); an item is taken at a
// clock edge with valid high and stall low, and each item gives one result
// in order. the front end registers and decodes items into a two-entry
// queue; the back end runs one item at a time against the region table and
// a single-port bitmap memory of one 64-bit word per access.
// mark or test of a known region passes the exec, update and out states
// from the queue head to the result register; a new region adds a wipe
// state that clears each bitmap word of the region, then a read state.
// clear, test of an unknown region and unused functions pass exec and out.
// an iteration step reads bitmap words in scan_rd and evaluates each in
// scan_ev, and steps past an empty slot in scan_rd alone.
// reset empties the region table, the count, the cursor and the queue and
// clears out_valid but not the result fields; bitmap words are wiped when
// a region is allocated. while out_stall holds a result, the next item is
// still taken into the queue until it fills, then in_stall rises.
module region_mark_bitmap_core #(
	parameter int REGION_SLOTS       = rmb_pkg::DEF_REGION_SLOTS,
	parameter int REGION_OFFSET_BITS = rmb_pkg::DEF_REGION_OFFSET,
	parameter int GRAIN_LOG          = rmb_pkg::DEF_GRAIN_LOG,
	parameter int BITS_PER_REGION    = rmb_pkg::DEF_BITS_PER_REGION,
	parameter int ADDR_BITS          = rmb_pkg::DEF_ADDR_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rmb_pkg::FUNC_W-1:0]  func,
	input  logic [rmb_pkg::ADDR_W-1:0]  addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        newly_marked,
	output logic                        is_marked,
	output logic                        table_full,
	output logic [rmb_pkg::COUNT_W-1:0] marked_total,
	output logic [rmb_pkg::ADDR_W-1:0]  next_addr,
	output logic                        iter_done
);
	import rmb_pkg::*;

	cmd_t front_cmd;
	cmd_t head;
	logic push, pop, q_full, q_empty;
	res_t res;

	rmb_front #(
		.ADDR_BITS(ADDR_BITS),
		.REGION_OFFSET_BITS(REGION_OFFSET_BITS),
		.GRAIN_LOG(GRAIN_LOG),
		.BITS_PER_REGION(BITS_PER_REGION)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .addr(addr),
		.push(push), .q_full(q_full), .cmd(front_cmd)
	);

	rmb_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_cmd(front_cmd),
		.pop(pop), .head(head),
		.full(q_full), .empty(q_empty)
	);

	rmb_back #(
		.REGION_SLOTS(REGION_SLOTS),
		.REGION_OFFSET_BITS(REGION_OFFSET_BITS),
		.GRAIN_LOG(GRAIN_LOG),
		.BITS_PER_REGION(BITS_PER_REGION)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .empty(q_empty), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .res(res)
	);

	assign newly_marked = res.newly_marked;
	assign is_marked    = res.is_marked;
	assign table_full   = res.table_full;
	assign marked_total = res.marked_total;
	assign next_addr    = res.next_addr;
	assign iter_done    = res.iter_done;

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue push while full");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("queue pop while empty");
	a_new_implies_marked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && newly_marked |-> is_marked && !table_full)
		else $error("new mark without mark bit");

endmodule

[tb/sv/region_mark_bitmap_core_test.sv]
`timescale 1ns / 1ps
// testbench of region_mark_bitmap_core: directed and random items checked against a predictor
module region_mark_bitmap_core_test;
	import rmb_pkg::*;

	localparam int SLOTS = 16;
	localparam int BITS = 4096;
	localparam int unsigned CYCLE_LIMIT = 16000000;

	class bitmap_scoreboard;
		res_t expected_q[$];
		int errors;
		logic [32:0] base_of[SLOTS];
		bit used[SLOTS];
		bit [BITS-1:0] marks[SLOTS];
		logic [COUNT_W-1:0] total;
		int cur_slot;
		int cur_bit;

		function new();
			errors = 0;
			total = 0;
			cur_slot = 0;
			cur_bit = 0;
			foreach (used[i]) begin
				used[i] = 0;
				marks[i] = '0;
			end
		endfunction

		function int slot_of(logic [32:0] b);
			for (int s = 0; s < SLOTS; s++)
				if (used[s] && base_of[s] == b) return s;
			return -1;
		endfunction

		function void note_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
			res_t r;
			logic [32:0] b;
			int idx;
			int s;
			bit found;
			r = '0;
			b = a[47:15];
			idx = int'(a[14:3]);
			found = 0;
			case (f)
				FUNC_MARK: begin
					s = slot_of(b);
					if (s < 0) begin
						for (int k = 0; k < SLOTS && s < 0; k++)
							if (!used[k]) s = k;
						if (s < 0) r.table_full = 1;
						else begin
							used[s] = 1;
							base_of[s] = b;
							marks[s] = '0;
						end
					end
					if (s >= 0) begin
						if (!marks[s][idx]) begin
							marks[s][idx] = 1;
							if (total != '1) total++;
							r.newly_marked = 1;
						end
						r.is_marked = 1;
					end
				end
				FUNC_TEST: begin
					s = slot_of(b);
					if (s >= 0) r.is_marked = marks[s][idx];
				end
				FUNC_CLEAR: begin
					foreach (used[i]) used[i] = 0;
					total = 0;
					cur_slot = 0;
					cur_bit = 0;
				end
				FUNC_ITER_FIRST, FUNC_ITER_NEXT: begin
					if (f == FUNC_ITER_FIRST) begin
						cur_slot = 0;
						cur_bit = 0;
					end
					for (int cs = cur_slot; cs < SLOTS && !found; cs++) begin
						if (!used[cs]) continue;
						for (int cb = (cs == cur_slot) ? cur_bit : 0; cb < BITS && !found; cb++)
							if (marks[cs][cb]) begin
								found = 1;
								r.next_addr = {base_of[cs], 12'(cb), 3'b000};
								cur_slot = (cb + 1 >= BITS) ? cs + 1 : cs;
								cur_bit = (cb + 1 >= BITS) ? 0 : cb + 1;
							end
					end
					if (!found) begin
						cur_slot = SLOTS;
						cur_bit = 0;
						r.iter_done = 1;
					end
				end
				default: ;
			endcase
			r.marked_total = total;
			expected_q.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		endtask

		task check_result(res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			e = expected_q.pop_front();
			if (got.newly_marked !== e.newly_marked)
				report("newly_marked", got.newly_marked, e.newly_marked);
			if (got.is_marked !== e.is_marked) report("is_marked", got.is_marked, e.is_marked);
			if (got.table_full !== e.table_full) report("table_full", got.table_full, e.table_full);
			if (got.marked_total !== e.marked_total)
				report("marked_total", got.marked_total, e.marked_total);
			if (got.next_addr !== e.next_addr) report("next_addr", got.next_addr, e.next_addr);
			if (got.iter_done !== e.iter_done) report("iter_done", got.iter_done, e.iter_done);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [ADDR_W-1:0] addr = '0;
	logic out_valid;
	logic out_stall = 0;
	logic newly_marked, is_marked, table_full, iter_done;
	logic [COUNT_W-1:0] marked_total;
	logic [ADDR_W-1:0] next_addr;

	bitmap_scoreboard sb = new();
	logic [32:0] base_pool[24];
	int results_seen = 0;
	int unsigned cycles = 0;

	region_mark_bitmap_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .addr(addr), .out_valid(out_valid), .out_stall(out_stall),
		.newly_marked(newly_marked), .is_marked(is_marked), .table_full(table_full),
		.marked_total(marked_total), .next_addr(next_addr), .iter_done(iter_done)
	);

	always #5 clk = ~clk;

	task send_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
		func <= f;
		addr <= a;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_item(f, a);
	endtask

	task idle_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	function logic [ADDR_W-1:0] pool_addr();
		return {base_pool[$urandom_range(0, 23)], 15'($urandom)};
	endfunction

	// receiver: random stall patterns, one long hold-off
	initial begin
		int hold_left;
		bit held;
		int mode;
		hold_left = 0;
		held = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result({newly_marked, is_marked, table_full, marked_total,
					next_addr, iter_done});
				results_seen++;
			end
			if (cycles % 200 == 0) mode = $urandom_range(0, 2);
			if (hold_left > 0) hold_left--;
			else if (!held && results_seen >= 300) begin
				held = 1;
				hold_left = 400;
			end
			out_stall <= (hold_left > 0) || (mode == 1 && $urandom_range(0, 2) == 0)
				|| (mode == 2 && cycles % 5 < 2);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [FUNC_W-1:0] f;
		int pick;
		base_pool[0] = '0;
		base_pool[1] = '1;
		for (int i = 2; i < 24; i++) base_pool[i] = 33'({$urandom, $urandom});
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, repeat mark, unknown region, unused funcs, full table
		send_item(FUNC_MARK, '0);
		send_item(FUNC_MARK, '1);
		send_item(FUNC_MARK, '1);
		send_item(FUNC_TEST, '0);
		send_item(FUNC_TEST, '1);
		send_item(FUNC_TEST, {base_pool[5], 15'h1234});
		send_item(FUNC_ITER_NEXT, '0);
		send_item(FUNC_ITER_FIRST, '1);
		send_item(FUNC_ITER_NEXT, '0);
		send_item(FUNC_ITER_NEXT, '0);
		send_item(3'd5, '1);
		send_item(3'd6, '0);
		send_item(3'd7, '1);
		for (int i = 2; i < 17; i++) send_item(FUNC_MARK, {base_pool[i], 15'h7fff});
		send_item(FUNC_TEST, {base_pool[16], 15'h7ff8});
		send_item(FUNC_CLEAR, '1);
		send_item(FUNC_TEST, '1);
		send_item(FUNC_ITER_FIRST, '0);
		drain();

		for (int n = 0; n < 1150; n++) begin
			if (n == 600) drain();
			pick = $urandom_range(0, 99);
			if (pick < 45) f = FUNC_MARK;
			else if (pick < 75) f = FUNC_TEST;
			else if (pick < 87) f = FUNC_ITER_NEXT;
			else if (pick < 92) f = FUNC_ITER_FIRST;
			else if (pick < 95) f = FUNC_CLEAR;
			else f = 3'($urandom_range(5, 7));
			send_item(f, ($urandom_range(0, 19) == 0) ? ADDR_W'({$urandom, $urandom}) :
				pool_addr());
			idle_gap();
		end
		drain();
		repeat (50) @(posedge clk);
		while (sb.expected_q.size() != 0) begin
			void'(sb.expected_q.pop_front());
			sb.report("missing result", 0, 1);
		end
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
